// File: hdl/lodd_pkg.sv
// Package for the lock-order deadlock detector: sizes, codes, sequencer states
// and a small helper function. Depends on nothing; every other file imports it.
`default_nettype none

package lodd_pkg;

    localparam int NUM_LOCKS   = 64;
    localparam int STACK_DEPTH = 16;

    localparam int LOCK_W  = $clog2(NUM_LOCKS);
    localparam int SIDX_W  = $clog2(STACK_DEPTH);
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

    typedef logic [LOCK_W-1:0]    lock_id_t;
    typedef logic [NUM_LOCKS-1:0] lock_mask_t;
    typedef logic [COUNT_W-1:0]   held_count_t;
    typedef logic [SIDX_W-1:0]    stack_idx_t;

    // Request codes.
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Status codes.
    localparam logic [2:0] STATUS_OK            = 3'd0;
    localparam logic [2:0] STATUS_DEADLOCK      = 3'd1;
    localparam logic [2:0] STATUS_REL_EMPTY     = 3'd2;
    localparam logic [2:0] STATUS_REL_NOT_TOP   = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW      = 3'd4;
    localparam logic [2:0] STATUS_HALTED        = 3'd5;

    localparam held_count_t STACK_FULL = COUNT_W'(STACK_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EDGE_CHK,
        ST_PICK,
        ST_MERGE
    } lodd_state_t;

    // Control from the sequencer to the reachability unit.
    typedef struct packed {
        logic init;   // start a new search from src
        logic take;   // the picked node is being expanded
        logic merge;  // fold the returned row into the masks
    } reach_ctrl_t;

    function automatic lock_mask_t lock_onehot(input lock_id_t id);
        lock_mask_t m;
        m = '0;
        m[id] = 1'b1;
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lodd_graph_mem.sv
// Lock-order adjacency matrix: one row of NUM_LOCKS bits per lock.
// Imports lodd_pkg. Rows never written read as zero through per-row valid bits.
`default_nettype none

module lodd_graph_mem
    import lodd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr_en,
    input  wire lock_id_t   wr_addr,
    input  wire lock_mask_t wr_data,
    input  wire logic       rd_en,
    input  wire lock_id_t   rd_addr,
    output lock_mask_t      rd_data
);

    lock_mask_t mem [NUM_LOCKS];
    lock_mask_t row_valid_reg;
    lock_mask_t rd_raw_reg;
    logic       rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

`default_nettype wire

// File: hdl/lodd_reach_unit.sv
// Reachability search masks: visited and pending sets with a lowest-pending pick.
// Imports lodd_pkg; driven one node at a time by the top-level sequencer.
`default_nettype none

module lodd_reach_unit
    import lodd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire reach_ctrl_t ctrl,
    input  wire lock_id_t    src,
    input  wire lock_mask_t  row,
    output logic             pick_valid,
    output lock_id_t         pick_node
);

    lock_mask_t visited_reg, visited_next;
    lock_mask_t pending_reg, pending_next;
    logic       found;

    always_comb
    begin
        pick_node = '0;
        found     = 1'b0;
        for (int i = 0; i < NUM_LOCKS; i++)
        begin
            if (pending_reg[i] && !found)
            begin
                pick_node = LOCK_W'(i);
                found     = 1'b1;
            end
        end
    end

    assign pick_valid = |pending_reg;

    always_comb
    begin
        visited_next = visited_reg;
        pending_next = pending_reg;
        if (ctrl.init)
        begin
            visited_next = lock_onehot(src);
            pending_next = lock_onehot(src);
        end
        else if (ctrl.take)
        begin
            pending_next = pending_reg & ~lock_onehot(pick_node);
        end
        else if (ctrl.merge)
        begin
            visited_next = visited_reg | row;
            pending_next = pending_reg | (row & ~visited_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            visited_reg <= visited_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lock_order_deadlock_detector_unit.sv
// Top level of the lock-order deadlock detector: sequencer, held-lock stack,
// status flags. Imports lodd_pkg; uses lodd_graph_mem and lodd_reach_unit.
//
//  Channel  | Signals                          | Handshake
//  ---------+----------------------------------+-----------------------------------
//  item in  | req_type, lock_id                | taken at a clock edge with start=1
//           |                                  | and busy=0
//  result   | status, new_edge, held_depth     | valid for one cycle while done=1;
//           |                                  | always taken, no backpressure
//
// A push, a pop, an error or an overflow is handled in ST_DECODE and then shown
// as the result, during which the next item may already be taken. An acquire
// whose edge already exists first reads the graph row of the top in ST_EDGE_CHK.
// An acquire that adds a new edge then searches from the new lock through the
// locks reachable from it, alternating ST_PICK and ST_MERGE; every node that the
// search expands costs one graph row read and one mask merge through the shared
// reachability unit, so the search expands at most NUM_LOCKS nodes.
// Reset clears the graph (through per-row valid bits), the stack depth and the
// halt flag at once; no clearing pass is needed. The receiver cannot stall.
`default_nettype none

module lock_order_deadlock_detector_unit
    import lodd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire logic     req_type,
    input  wire lock_id_t lock_id,
    output logic          done,
    output logic [2:0]    status,
    output logic          new_edge,
    output held_count_t   held_depth
);

    // Sequencer and item registers.
    lodd_state_t state_reg, state_next;
    logic        req_reg;
    lock_id_t    id_reg;
    lock_id_t    top_reg, top_next;

    // Architectural state.
    held_count_t count_reg, count_next;
    logic        halted_reg, halted_next;
    lock_id_t    stack_reg [STACK_DEPTH];

    // Result registers.
    logic        done_reg, done_next;
    logic [2:0]  status_reg, status_next;
    logic        new_edge_reg, new_edge_next;

    // Graph memory and search unit connections.
    logic        wr_en;
    lock_mask_t  wr_data;
    logic        rd_en;
    lock_id_t    rd_addr;
    lock_mask_t  rd_data;
    reach_ctrl_t reach_ctrl;
    logic        pick_valid;
    lock_id_t    pick_node;

    logic        push_en;
    stack_idx_t  top_idx;
    lock_id_t    stack_top;

    // The top entry is only looked at while the stack is not empty.
    assign top_idx   = count_reg[SIDX_W-1:0] - SIDX_W'(1);
    assign stack_top = stack_reg[top_idx];

    lodd_graph_mem u_graph (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (top_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lodd_reach_unit u_reach (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (reach_ctrl),
        .src        (id_reg),
        .row        (rd_data),
        .pick_valid (pick_valid),
        .pick_node  (pick_node)
    );

    always_comb
    begin
        state_next    = state_reg;
        top_next      = top_reg;
        count_next    = count_reg;
        halted_next   = halted_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        new_edge_next = new_edge_reg;
        wr_en         = 1'b0;
        wr_data       = rd_data | lock_onehot(id_reg);
        rd_en         = 1'b0;
        rd_addr       = stack_top;
        reach_ctrl    = '0;
        push_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                new_edge_next = 1'b0;
                status_next   = STATUS_OK;
                state_next    = ST_IDLE;
                done_next     = 1'b1;
                if (halted_reg)
                begin
                    status_next = STATUS_HALTED;
                end
                else if (req_reg == REQ_ACQUIRE)
                begin
                    if (count_reg >= STACK_FULL)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else if ((count_reg != '0) && (id_reg != stack_top))
                    begin
                        // Look up the row of the current top to see if the edge exists.
                        rd_en      = 1'b1;
                        top_next   = stack_top;
                        done_next  = 1'b0;
                        state_next = ST_EDGE_CHK;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_REL_EMPTY;
                        halted_next = 1'b1;
                    end
                    else if (stack_top != id_reg)
                    begin
                        status_next = STATUS_REL_NOT_TOP;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
            end

            ST_EDGE_CHK:
            begin
                if (rd_data[id_reg])
                begin
                    push_en    = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Record the new edge and search for a path back to the top.
                    wr_en           = 1'b1;
                    new_edge_next   = 1'b1;
                    reach_ctrl.init = 1'b1;
                    state_next      = ST_PICK;
                end
            end

            ST_PICK:
            begin
                rd_addr = pick_node;
                if (!pick_valid)
                begin
                    push_en    = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (pick_node == top_reg)
                begin
                    status_next = STATUS_DEADLOCK;
                    halted_next = 1'b1;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rd_en           = 1'b1;
                    reach_ctrl.take = 1'b1;
                    state_next      = ST_MERGE;
                end
            end

            ST_MERGE:
            begin
                reach_ctrl.merge = 1'b1;
                state_next       = ST_PICK;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
        begin
            req_reg <= req_type;
            id_reg  <= lock_id;
        end
        if (push_en)
        begin
            stack_reg[count_reg[SIDX_W-1:0]] <= id_reg;
        end
        top_reg      <= top_next;
        status_reg   <= status_next;
        new_edge_reg <= new_edge_next;
    end

    // The stack depth only changes at the edge that raises done, so it is
    // shown directly as the result depth.
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign new_edge   = new_edge_reg;
    assign held_depth = count_reg;

endmodule

`default_nettype wire

// File: hdl/lodd_checker.sv
// Port-level checks for the lock-order deadlock detector, with the bind that
// attaches them to lock_order_deadlock_detector_unit. Imports lodd_pkg.
`default_nettype none

module lodd_checker
    import lodd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic        new_edge,
    input wire held_count_t held_depth
);

    // A result is only shown once the item's work is over.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // Every result follows a cycle of work on an item.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // A taken item makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

    // A deadlock is always reported together with the edge that closed it.
    a_deadlock_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_DEADLOCK)) |-> new_edge)
        else $error("deadlock without new edge");

    // The held depth never exceeds the stack.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (held_depth <= STACK_FULL))
        else $error("held depth beyond stack size");

endmodule

bind lock_order_deadlock_detector_unit lodd_checker u_lodd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .new_edge   (new_edge),
    .held_depth (held_depth)
);

`default_nettype wire
